// ===== rtl/bmffa_pkg.sv =====
`default_nettype none
package bmffa_pkg;

	localparam logic OP_ALLOCATE = 1'b0;
	localparam logic OP_FREE     = 1'b1;

	localparam logic [2:0] ST_ALLOCATED    = 3'd0;
	localparam logic [2:0] ST_BAD_SIZE     = 3'd1;
	localparam logic [2:0] ST_NO_SPACE     = 3'd2;
	localparam logic [2:0] ST_FREED        = 3'd3;
	localparam logic [2:0] ST_FREE_IGNORED = 3'd4;

	localparam logic [31:0] BASE_ADDR_RESET = 32'h2000_1000;

	typedef struct packed {
		logic        operation;
		logic [15:0] request_bytes;
		logic [31:0] release_address;
	} req_t;

	typedef struct packed {
		logic [31:0] granted_address;
		logic [2:0]  status;
	} res_t;

endpackage
`default_nettype wire

// ===== rtl/bmffa_ram.sv =====
`default_nettype none
module bmffa_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 256
) (
	input  wire                       clk,
	input  wire                       we,
	input  wire [$clog2(DEPTH)-1:0]   wr_addr,
	input  wire [WIDTH-1:0]           wr_data,
	input  wire                       rd_en,
	input  wire [$clog2(DEPTH)-1:0]   rd_addr,
	output logic [WIDTH-1:0]          rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule
`default_nettype wire

// ===== rtl/bmffa_engine.sv =====
`default_nettype none
module bmffa_engine #(
	parameter int BLOCK_BYTES = 16,
	parameter int BLOCK_TOTAL = 256
) (
	input  wire              clk,
	input  wire              arst_n,
	input  wire [31:0]       base_addr,
	input  wire              start,
	input  bmffa_pkg::req_t  req,
	output logic             idle,
	output logic             res_valid,
	output bmffa_pkg::res_t  res,
	input  wire              res_take
);
	import bmffa_pkg::*;

	localparam int unsigned SPAN = BLOCK_BYTES * BLOCK_TOTAL;
	localparam int OFF_W = $clog2(SPAN + 1);
	localparam int IW = $clog2(BLOCK_TOTAL);

	localparam logic [2:0] S_CLEAR = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_ASCAN = 3'd2;
	localparam logic [2:0] S_AMARK = 3'd3;
	localparam logic [2:0] S_FLOC  = 3'd4;
	localparam logic [2:0] S_FCLR  = 3'd5;
	localparam logic [2:0] S_WAIT  = 3'd6;

	logic [2:0]       state_q;
	logic [IW-1:0]    chk_q;
	logic [IW-1:0]    first_idx_q;
	logic [IW-1:0]    mk_q;
	logic [IW-1:0]    end_q;
	logic [OFF_W-1:0] cur_off_q;
	logic [OFF_W-1:0] first_off_q;
	logic [OFF_W-1:0] run_bytes_q;
	logic [OFF_W-1:0] rel_q;
	logic [15:0]      bytes_q;
	res_t             res_q;

	logic             we;
	logic [IW-1:0]    wr_addr;
	logic [0:0]       wr_data;
	logic             rd_en;
	logic [IW-1:0]    rd_addr;
	logic [0:0]       rd_data;

	logic             is_last;
	logic [31:0]      run_next;
	logic             fit;
	logic             blk_free;
	logic [IW-1:0]    start_idx;
	logic [OFF_W-1:0] start_off;
	logic [OFF_W-1:0] off_next;
	logic             past_blk;
	logic             bad_size;
	logic [33:0]      addr_ext;
	logic [33:0]      base_ext;
	logic             free_ign;
	logic [31:0]      rel_full;

	bmffa_ram #(
		.WIDTH(1),
		.DEPTH(BLOCK_TOTAL)
	) u_map (
		.clk    (clk),
		.we     (we),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	assign is_last   = (chk_q == IW'(BLOCK_TOTAL - 1));
	assign run_next  = 32'(run_bytes_q) + 32'(BLOCK_BYTES);
	assign fit       = (run_next >= {16'd0, bytes_q});
	assign blk_free  = (rd_data[0] == 1'b0);
	assign start_idx = (run_bytes_q == '0) ? chk_q : first_idx_q;
	assign start_off = (run_bytes_q == '0) ? cur_off_q : first_off_q;
	assign off_next  = cur_off_q + OFF_W'(BLOCK_BYTES);
	assign past_blk  = (rel_q >= off_next);
	assign bad_size  = (req.request_bytes == 16'd0) ||
		({16'd0, req.request_bytes} > 32'(SPAN));
	assign addr_ext  = {2'b00, req.release_address};
	assign base_ext  = {2'b00, base_addr};
	assign free_ign  = (req.release_address == 32'd0) || (addr_ext < base_ext) ||
		(addr_ext >= base_ext + 34'(SPAN));
	assign rel_full  = req.release_address - base_addr;

	assign idle      = (state_q == S_IDLE);
	assign res_valid = (state_q == S_WAIT);
	assign res       = res_q;

	always_comb begin
		we      = 1'b0;
		wr_addr = chk_q;
		wr_data = 1'b0;
		rd_en   = 1'b0;
		rd_addr = chk_q;
		unique case (state_q)
			S_CLEAR: begin
				we = 1'b1;
			end
			S_IDLE: begin
				if (start && req.operation == OP_ALLOCATE && !bad_size) begin
					rd_en   = 1'b1;
					rd_addr = '0;
				end
			end
			S_ASCAN: begin
				if (!(blk_free && fit) && !is_last) begin
					rd_en   = 1'b1;
					rd_addr = chk_q + 1'b1;
				end
			end
			S_AMARK: begin
				we      = 1'b1;
				wr_addr = mk_q;
				wr_data = 1'b1;
			end
			S_FLOC: begin
				rd_en = !past_blk;
			end
			S_FCLR: begin
				if (!blk_free) begin
					we = 1'b1;
					if (!is_last) begin
						rd_en   = 1'b1;
						rd_addr = chk_q + 1'b1;
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			chk_q       <= '0;
			first_idx_q <= '0;
			mk_q        <= '0;
			end_q       <= '0;
			cur_off_q   <= '0;
			first_off_q <= '0;
			run_bytes_q <= '0;
			rel_q       <= '0;
			bytes_q     <= '0;
			res_q       <= '0;
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					chk_q <= chk_q + 1'b1;
					if (is_last) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (start) begin
						res_q.granted_address <= 32'd0;
						if (req.operation == OP_ALLOCATE) begin
							bytes_q     <= req.request_bytes;
							run_bytes_q <= '0;
							chk_q       <= '0;
							cur_off_q   <= '0;
							if (bad_size) begin
								res_q.status <= ST_BAD_SIZE;
								state_q      <= S_WAIT;
							end else begin
								state_q <= S_ASCAN;
							end
						end else begin
							rel_q     <= rel_full[OFF_W-1:0];
							chk_q     <= '0;
							cur_off_q <= '0;
							if (free_ign) begin
								res_q.status <= ST_FREE_IGNORED;
								state_q      <= S_WAIT;
							end else begin
								state_q <= S_FLOC;
							end
						end
					end
				end
				S_ASCAN: begin
					if (blk_free && fit) begin
						first_off_q <= start_off;
						mk_q        <= start_idx;
						end_q       <= chk_q;
						state_q     <= S_AMARK;
					end else begin
						if (blk_free) begin
							first_idx_q <= start_idx;
							first_off_q <= start_off;
							run_bytes_q <= run_next[OFF_W-1:0];
						end else begin
							run_bytes_q <= '0;
						end
						if (is_last) begin
							res_q.status <= ST_NO_SPACE;
							state_q      <= S_WAIT;
						end else begin
							chk_q     <= chk_q + 1'b1;
							cur_off_q <= off_next;
						end
					end
				end
				S_AMARK: begin
					mk_q <= mk_q + 1'b1;
					if (mk_q == end_q) begin
						res_q.granted_address <= base_addr + 32'(first_off_q);
						res_q.status          <= ST_ALLOCATED;
						state_q               <= S_WAIT;
					end
				end
				S_FLOC: begin
					// step to the block that holds the address, read it on arrival
					if (past_blk) begin
						chk_q     <= chk_q + 1'b1;
						cur_off_q <= off_next;
					end else begin
						state_q <= S_FCLR;
					end
				end
				S_FCLR: begin
					if (blk_free || is_last) begin
						res_q.status <= ST_FREED;
						state_q      <= S_WAIT;
					end else begin
						chk_q <= chk_q + 1'b1;
					end
				end
				S_WAIT: begin
					if (res_take) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== rtl/block_map_first_fit_allocator.sv =====
`default_nettype none
// First-fit allocator over BLOCK_TOTAL blocks of BLOCK_BYTES bytes, one used bit per
// block kept in a one-bit-wide RAM that is touched one block per cycle. After reset
// a clearing pass over every block runs, during which no request is taken
// (base address writes are). An allocate scans the blocks from the first up to the
// end of the first fitting run (at most BLOCK_TOTAL blocks), then marks the blocks of
// that run used and presents the result; a bad size answers without a scan. A free
// steps to the block holding the address, then clears used blocks from there until
// it meets a free block or the last block; an ignored free answers without a
// step. The RAM has a single read and write port. Results leave through an output
// register, so a request is taken while the previous result still waits.
module block_map_first_fit_allocator #(
	parameter int BLOCK_BYTES = 16,
	parameter int BLOCK_TOTAL = 256
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         cfg_valid,
	output logic        cfg_ready,
	input  wire  [31:0] cfg_data,
	input  wire         request_valid,
	output logic        request_stall,
	input  wire         operation,
	input  wire  [15:0] request_bytes,
	input  wire  [31:0] release_address,
	output logic        result_valid,
	input  wire         result_stall,
	output logic [31:0] granted_address,
	output logic [2:0]  status
);
	import bmffa_pkg::*;

	logic [31:0] base_addr_q;
	logic        eng_idle;
	logic        eng_res_valid;
	res_t        eng_res;
	req_t        req;
	logic        res_take;
	logic        result_valid_q;
	logic [31:0] granted_address_q;
	logic [2:0]  status_q;

	assign cfg_ready     = 1'b1;
	assign request_stall = !eng_idle;
	assign req.operation       = operation;
	assign req.request_bytes   = request_bytes;
	assign req.release_address = release_address;
	assign res_take      = !result_valid_q || !result_stall;

	bmffa_engine #(
		.BLOCK_BYTES(BLOCK_BYTES),
		.BLOCK_TOTAL(BLOCK_TOTAL)
	) u_engine (
		.clk      (clk),
		.arst_n   (arst_n),
		.base_addr(base_addr_q),
		.start    (request_valid && eng_idle),
		.req      (req),
		.idle     (eng_idle),
		.res_valid(eng_res_valid),
		.res      (eng_res),
		.res_take (res_take)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_addr_q <= BASE_ADDR_RESET;
		end else if (cfg_valid) begin
			base_addr_q <= cfg_data;
		end
	end

	// hold the result until the consumer takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (eng_res_valid && res_take) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (eng_res_valid && res_take) begin
			granted_address_q <= eng_res.granted_address;
			status_q          <= eng_res.status;
		end
	end

	assign result_valid    = result_valid_q;
	assign granted_address = granted_address_q;
	assign status          = status_q;

endmodule
`default_nettype wire
